### design/cct_mix_pkg.sv
// Shared types, constants and table functions of the CCT LED channel mixer.
// No dependencies; every other file of the block imports this package.
package cct_mix_pkg;

   // Fixed-point format and gamma table resolution
   localparam int FRACTION_BITS    = 12;
   localparam int GAMMA_INDEX_BITS = 12;
   localparam int ONE              = 1 << FRACTION_BITS;
   localparam int HALF             = ONE >> 1;

   // Port field widths
   localparam int TEMP_W  = 16;
   localparam int LEVEL_W = 13;
   localparam int DUTY_W  = 13;
   localparam int MODE_W  = 2;

   // Internal widths
   localparam int VAL_W      = FRACTION_BITS + 1;
   localparam int NUM_CH     = 4;
   localparam int NUM_KNOTS  = 5;
   localparam int NUM_SEG    = NUM_KNOTS - 1;
   localparam int SEG_W      = 2;
   localparam int DIFF_W     = 11;
   localparam int SPAN_W     = 11;
   localparam int SLOPE_W    = FRACTION_BITS + 2;
   localparam int PROD_W     = SLOPE_W + DIFF_W + 1;
   localparam int NUM_W      = FRACTION_BITS + SPAN_W;
   localparam int RECIP_W    = FRACTION_BITS + 3;
   localparam int RECIP_SHIFT = NUM_W;
   localparam int QP_W       = NUM_W + RECIP_W;
   localparam int QS_W       = VAL_W + SPAN_W;
   localparam int LVL_CMP_W  = (VAL_W > LEVEL_W) ? VAL_W : LEVEL_W;

   // Night scaling: x*gain + 5, then divide by ten through a reciprocal
   localparam int NIGHT_W         = FRACTION_BITS + 4;
   localparam int NIGHT_RED_GAIN  = 12;
   localparam int NIGHT_BLUE_GAIN = 3;
   localparam int NIGHT_ROUND     = 5;
   localparam int DIV10_SHIFT     = NIGHT_W + 4;
   localparam int DIV10_W         = FRACTION_BITS + 5;
   localparam int DIV10_MUL       = (1 << DIV10_SHIFT) / 10 + 1;
   localparam int DQ_W            = NIGHT_W + DIV10_W;

   // Gamma lookup
   localparam int K_W       = GAMMA_INDEX_BITS + 1;
   localparam int KC_W      = VAL_W + GAMMA_INDEX_BITS;
   localparam int ROM_DEPTH = (1 << GAMMA_INDEX_BITS) + 1;
   localparam int CALC_W    = 11 * (FRACTION_BITS + 1) + 5 * GAMMA_INDEX_BITS + 2;

   // Light mode codes
   localparam logic [MODE_W-1:0] LIGHT_DAY   = 2'd0;
   localparam logic [MODE_W-1:0] LIGHT_NIGHT = 2'd2;

   // Knot temperatures in kelvin and knot duties in hundredths
   localparam int KNOT_T [NUM_KNOTS] = '{2700, 3000, 4000, 5000, 6500};
   localparam int KNOT_HUND [NUM_KNOTS][NUM_CH] = '{
      '{5, 95, 8, 0},
      '{15, 85, 7, 1},
      '{45, 55, 5, 2},
      '{70, 30, 3, 4},
      '{90, 10, 1, 6}
   };

   // Per-segment lower knot, span and span reciprocal
   localparam int SEG_LO [NUM_SEG] = '{KNOT_T[0], KNOT_T[1], KNOT_T[2], KNOT_T[3]};
   localparam int SEG_SPAN [NUM_SEG] = '{
      KNOT_T[1] - KNOT_T[0], KNOT_T[2] - KNOT_T[1],
      KNOT_T[3] - KNOT_T[2], KNOT_T[4] - KNOT_T[3]
   };
   localparam int SEG_RECIP [NUM_SEG] = '{
      (1 << RECIP_SHIFT) / (KNOT_T[1] - KNOT_T[0]),
      (1 << RECIP_SHIFT) / (KNOT_T[2] - KNOT_T[1]),
      (1 << RECIP_SHIFT) / (KNOT_T[3] - KNOT_T[2]),
      (1 << RECIP_SHIFT) / (KNOT_T[4] - KNOT_T[3])
   };

   // Item payloads
   typedef struct packed {
      logic [TEMP_W-1:0]  color_temp;
      logic [LEVEL_W-1:0] brightness_level;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_ch1;
      logic [DUTY_W-1:0] duty_ch2;
      logic [DUTY_W-1:0] duty_ch3;
      logic [DUTY_W-1:0] duty_ch4;
   } rsp_type;

   // Interpolated duties plus clamped brightness, between the two sections
   typedef struct packed {
      logic [NUM_CH-1:0][VAL_W-1:0] duty;
      logic [VAL_W-1:0]             level;
   } mix_type;

   // Knot duty in Q format, rounded from hundredths
   function automatic int knot_duty(input int i, input int ch);
      return (KNOT_HUND[i][ch] * ONE + 50) / 100;
   endfunction

   // Numerator offset of a segment: p0*span + span/2
   function automatic logic [NUM_W-1:0] seg_base(input int s, input int ch);
      return NUM_W'(knot_duty(s, ch) * SEG_SPAN[s] + (SEG_SPAN[s] >> 1));
   endfunction

   // Duty change across a segment: p1 - p0
   function automatic logic signed [SLOPE_W-1:0] seg_slope(input int s, input int ch);
      return SLOPE_W'(knot_duty(s + 1, ch) - knot_duty(s, ch));
   endfunction

   // Gamma entry: largest y with y^11 * 2^(5G) <= k^5 * 2^(11(F+1)), halved and rounded
   function automatic logic [VAL_W-1:0] gamma_entry(input int k);
      logic [CALC_W-1:0] rhs;
      logic [CALC_W-1:0] lhs;
      int lo;
      int hi;
      int mid;
      int y;
      int j;
      rhs = CALC_W'(1);
      for (j = 0; j < 5; j++) begin
         rhs = rhs * CALC_W'(k);
      end
      rhs = rhs << (11 * (FRACTION_BITS + 1));
      lo = 0;
      hi = 2 * ONE;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         lhs = CALC_W'(1);
         for (j = 0; j < 11; j++) begin
            lhs = lhs * CALC_W'(mid);
         end
         lhs = lhs << (5 * GAMMA_INDEX_BITS);
         if (lhs <= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      y = (lo + 1) >> 1;
      if (y > ONE) begin
         y = ONE;
      end
      return VAL_W'(y);
   endfunction

endpackage

### design/cct_mix_interp.sv
// Interpolation section: clamp, segment select, numerator, reciprocal divide, correction.
// Four register stages; depends on cct_mix_pkg.
module cct_mix_interp
   import cct_mix_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    out_valid,
   input  logic    out_ready,
   output mix_type out_item
);

   logic adv1, adv2, adv3, adv4;

   // Stage 1 registers
   logic             s1_vld_ff;
   logic [SEG_W-1:0] s1_seg_ff, s1_seg_in;
   logic [DIFF_W-1:0] s1_d_ff, s1_d_in;
   logic [VAL_W-1:0] s1_lvl_ff, s1_lvl_in;
   logic [TEMP_W-1:0] s1_temp;
   logic [TEMP_W-1:0] s1_dfull;

   // Stage 2 registers
   logic             s2_vld_ff;
   logic [SEG_W-1:0] s2_seg_ff;
   logic [VAL_W-1:0] s2_lvl_ff;
   logic [NUM_W-1:0] s2_num_ff [NUM_CH];
   logic [NUM_W-1:0] s2_num_in [NUM_CH];
   logic signed [PROD_W-1:0] s2_sum [NUM_CH];

   // Stage 3 registers
   logic             s3_vld_ff;
   logic [SEG_W-1:0] s3_seg_ff;
   logic [VAL_W-1:0] s3_lvl_ff;
   logic [NUM_W-1:0] s3_num_ff [NUM_CH];
   logic [VAL_W-1:0] s3_q_ff [NUM_CH];
   logic [VAL_W-1:0] s3_q_in [NUM_CH];
   logic [QP_W-1:0]  s3_prod [NUM_CH];

   // Stage 4 registers
   logic             s4_vld_ff;
   logic [VAL_W-1:0] s4_lvl_ff;
   logic [VAL_W-1:0] s4_duty_ff [NUM_CH];
   logic [VAL_W-1:0] s4_duty_in [NUM_CH];
   logic [QS_W-1:0]  s4_qspan [NUM_CH];
   logic [QS_W-1:0]  s4_rem [NUM_CH];

   // Advance a stage when it is empty or the next one advances
   assign adv4     = !s4_vld_ff || out_ready;
   assign adv3     = !s3_vld_ff || adv4;
   assign adv2     = !s2_vld_ff || adv3;
   assign adv1     = !s1_vld_ff || adv2;
   assign in_ready = adv1;

   // Clamp temperature, pick the segment, take the offset into it; saturate brightness
   always_comb begin
      s1_temp = in_item.color_temp;
      if (s1_temp < TEMP_W'(KNOT_T[0])) begin
         s1_temp = TEMP_W'(KNOT_T[0]);
      end
      if (s1_temp > TEMP_W'(KNOT_T[NUM_KNOTS-1])) begin
         s1_temp = TEMP_W'(KNOT_T[NUM_KNOTS-1]);
      end
      if (s1_temp <= TEMP_W'(KNOT_T[1])) begin
         s1_seg_in = SEG_W'(0);
      end else if (s1_temp <= TEMP_W'(KNOT_T[2])) begin
         s1_seg_in = SEG_W'(1);
      end else if (s1_temp <= TEMP_W'(KNOT_T[3])) begin
         s1_seg_in = SEG_W'(2);
      end else begin
         s1_seg_in = SEG_W'(3);
      end
      s1_dfull = s1_temp - TEMP_W'(SEG_LO[s1_seg_in]);
      s1_d_in  = s1_dfull[DIFF_W-1:0];
      if (LVL_CMP_W'(in_item.brightness_level) > LVL_CMP_W'(ONE)) begin
         s1_lvl_in = VAL_W'(ONE);
      end else begin
         s1_lvl_in = VAL_W'(in_item.brightness_level);
      end
   end

   // Numerator: p0*span + span/2 + (p1-p0)*d
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s2_sum[ch] = seg_slope(int'(s1_seg_ff), ch) * $signed({1'b0, s1_d_ff})
                    + $signed({1'b0, seg_base(int'(s1_seg_ff), ch)});
         s2_num_in[ch] = s2_sum[ch][NUM_W-1:0];
      end
   end

   // Estimate the quotient by the span reciprocal; it is exact or one low
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s3_prod[ch] = QP_W'(s2_num_ff[ch]) * QP_W'(SEG_RECIP[s2_seg_ff]);
         s3_q_in[ch] = s3_prod[ch][RECIP_SHIFT +: VAL_W];
      end
   end

   // Correct the estimate with one remainder compare
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s4_qspan[ch] = QS_W'(s3_q_ff[ch]) * QS_W'(SEG_SPAN[s3_seg_ff]);
         s4_rem[ch]   = QS_W'(s3_num_ff[ch]) - s4_qspan[ch];
         if (s4_rem[ch] >= QS_W'(SEG_SPAN[s3_seg_ff])) begin
            s4_duty_in[ch] = s3_q_ff[ch] + VAL_W'(1);
         end else begin
            s4_duty_in[ch] = s3_q_ff[ch];
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_vld_ff <= in_valid;
         end
         if (adv2) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (adv3) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (adv4) begin
            s4_vld_ff <= s3_vld_ff;
         end
      end
   end

   // Payload registers, held while stalled
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_seg_ff <= s1_seg_in;
         s1_d_ff   <= s1_d_in;
         s1_lvl_ff <= s1_lvl_in;
      end
      if (adv2) begin
         s2_seg_ff <= s1_seg_ff;
         s2_lvl_ff <= s1_lvl_ff;
         s2_num_ff <= s2_num_in;
      end
      if (adv3) begin
         s3_seg_ff <= s2_seg_ff;
         s3_lvl_ff <= s2_lvl_ff;
         s3_num_ff <= s2_num_ff;
         s3_q_ff   <= s3_q_in;
      end
      if (adv4) begin
         s4_lvl_ff  <= s3_lvl_ff;
         s4_duty_ff <= s4_duty_in;
      end
   end

   // Drive the section output
   assign out_valid = s4_vld_ff;
   always_comb begin
      out_item.level = s4_lvl_ff;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         out_item.duty[ch] = s4_duty_ff[ch];
      end
   end

endmodule

### design/cct_mix_gamma_rom.sv
// Gamma 1/2.2 lookup ROM with a registered read port.
// Contents are computed at elaboration by gamma_entry from cct_mix_pkg.
module cct_mix_gamma_rom
   import cct_mix_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [K_W-1:0]   rd_addr,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0] rom_entry [ROM_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   // Fill the table with constant entries
   for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_entry
      localparam logic [VAL_W-1:0] ENTRY_VALUE = gamma_entry(k);
      assign rom_entry[k] = ENTRY_VALUE;
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_entry[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cct_mix_scale.sv
// Output section: night scaling, clamp and brightness product, gamma lookup.
// Three register stages, the last being the ROM read; depends on cct_mix_pkg, cct_mix_gamma_rom.
module cct_mix_scale
   import cct_mix_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [MODE_W-1:0] light_mode,
   input  logic              in_valid,
   output logic              in_ready,
   input  mix_type           in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output rsp_type           out_item
);

   logic adv5, adv6, adv7;

   // Stage 5 registers
   logic             s5_vld_ff;
   logic [VAL_W-1:0] s5_lvl_ff;
   logic [VAL_W-1:0] s5_duty_ff [NUM_CH];
   logic [VAL_W-1:0] s5_duty_in [NUM_CH];
   logic [NIGHT_W-1:0] s5_red_num, s5_blue_num;
   logic [DQ_W-1:0]    s5_red_prod, s5_blue_prod;

   // Stage 6 registers
   logic             s6_vld_ff;
   logic [VAL_W-1:0] s6_prod_ff [NUM_CH];
   logic [VAL_W-1:0] s6_prod_in [NUM_CH];
   logic [VAL_W-1:0] s6_clamp [NUM_CH];
   logic [2*VAL_W-1:0] s6_mul [NUM_CH];

   // Stage 7: ROM output registers
   logic             s7_vld_ff;
   logic [KC_W-1:0]  s7_kc [NUM_CH];
   logic [K_W-1:0]   s7_addr [NUM_CH];
   logic [VAL_W-1:0] s7_data [NUM_CH];

   // Advance a stage when it is empty or the next one advances
   assign adv7     = !s7_vld_ff || out_ready;
   assign adv6     = !s6_vld_ff || adv7;
   assign adv5     = !s5_vld_ff || adv6;
   assign in_ready = adv5;

   // Night mode: boost red, suppress blue; divide by ten through a reciprocal
   always_comb begin
      s5_red_num   = NIGHT_W'(in_item.duty[2]) * NIGHT_W'(NIGHT_RED_GAIN)
                   + NIGHT_W'(NIGHT_ROUND);
      s5_blue_num  = NIGHT_W'(in_item.duty[3]) * NIGHT_W'(NIGHT_BLUE_GAIN)
                   + NIGHT_W'(NIGHT_ROUND);
      s5_red_prod  = DQ_W'(s5_red_num) * DQ_W'(DIV10_MUL);
      s5_blue_prod = DQ_W'(s5_blue_num) * DQ_W'(DIV10_MUL);
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s5_duty_in[ch] = in_item.duty[ch];
      end
      if (light_mode == LIGHT_NIGHT) begin
         s5_duty_in[2] = s5_red_prod[DIV10_SHIFT +: VAL_W];
         s5_duty_in[3] = s5_blue_prod[DIV10_SHIFT +: VAL_W];
      end
   end

   // Clamp to full scale and apply brightness with rounding
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (s5_duty_ff[ch] > VAL_W'(ONE)) begin
            s6_clamp[ch] = VAL_W'(ONE);
         end else begin
            s6_clamp[ch] = s5_duty_ff[ch];
         end
         s6_mul[ch] = (2*VAL_W)'(s6_clamp[ch]) * (2*VAL_W)'(s5_lvl_ff)
                    + (2*VAL_W)'(HALF);
         s6_prod_in[ch] = s6_mul[ch][FRACTION_BITS +: VAL_W];
      end
   end

   // Rescale the product to a gamma table index
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s7_kc[ch]   = (KC_W'(s6_prod_ff[ch]) << GAMMA_INDEX_BITS) + KC_W'(HALF);
         s7_addr[ch] = s7_kc[ch][FRACTION_BITS +: K_W];
      end
   end

   // One ROM per channel
   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_rom
      cct_mix_gamma_rom u_rom (
         .clock   (clock),
         .rd_en   (adv7),
         .rd_addr (s7_addr[ch]),
         .rd_data (s7_data[ch])
      );
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else begin
         if (adv5) begin
            s5_vld_ff <= in_valid;
         end
         if (adv6) begin
            s6_vld_ff <= s5_vld_ff;
         end
         if (adv7) begin
            s7_vld_ff <= s6_vld_ff;
         end
      end
   end

   // Payload registers, held while stalled
   always_ff @(posedge clock) begin
      if (adv5) begin
         s5_lvl_ff  <= in_item.level;
         s5_duty_ff <= s5_duty_in;
      end
      if (adv6) begin
         s6_prod_ff <= s6_prod_in;
      end
   end

   // Drive the result item
   assign out_valid         = s7_vld_ff;
   assign out_item.duty_ch1 = DUTY_W'(s7_data[0]);
   assign out_item.duty_ch2 = DUTY_W'(s7_data[1]);
   assign out_item.duty_ch3 = DUTY_W'(s7_data[2]);
   assign out_item.duty_ch4 = DUTY_W'(s7_data[3]);

endmodule

### design/cct_led_channel_mixer.sv
// Top level of the CCT LED channel mixer: mode register and the two pipeline sections.
// Depends on cct_mix_pkg, cct_mix_interp and cct_mix_scale.
//
//   channel  ports                                 dir  item
//   req      req_valid, req_ready, req_data        in   color_temp, brightness_level
//   rsp      rsp_valid, rsp_ready, rsp_data        out  duty_ch1 .. duty_ch4
//   csr      csr_valid, csr_ready, csr_light_mode  in   light_mode
//
// One item per cycle while rsp is not stalled; rsp_valid is set through seven
// register stages, the first loaded at the accepting edge and the gamma ROM
// read the last.
// Reset clears every stage valid bit and sets light_mode to day.
// A stall on rsp holds only the full stages; empty stages keep filling, so
// req_ready drops only once every stage holds an item.
module cct_led_channel_mixer
   import cct_mix_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [MODE_W-1:0] csr_light_mode
);

   logic [MODE_W-1:0] light_mode_ff;
   logic              mid_valid;
   logic              mid_ready;
   mix_type           mid_item;

   // Mode register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         light_mode_ff <= LIGHT_DAY;
      end else if (csr_valid) begin
         light_mode_ff <= csr_light_mode;
      end
   end

   // Interpolation stages
   cct_mix_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   // Scaling and gamma stages
   cct_mix_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .light_mode (light_mode_ff),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_item    (mid_item),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_item   (rsp_data)
   );

endmodule

### design/cct_mix_checker.sv
// Port-level checks of the CCT LED channel mixer, bound to the top level.
// Depends on cct_mix_pkg and cct_led_channel_mixer.
module cct_mix_checker
   import cct_mix_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Duties never exceed full scale
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.duty_ch1 <= DUTY_W'(ONE)) && (rsp_data.duty_ch2 <= DUTY_W'(ONE))
                 && (rsp_data.duty_ch3 <= DUTY_W'(ONE)) && (rsp_data.duty_ch4 <= DUTY_W'(ONE)))
      else $error("duty above full scale");

   // Empty pipe after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // With no result waiting, the pipe cannot be full
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output is empty");

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind cct_led_channel_mixer cct_mix_checker u_cct_mix_checker (.*);

### sim/cct_led_channel_mixer_tb.sv
// Self-checking bench for cct_led_channel_mixer: random valid/ready traffic on req and rsp,
// light mode writes between phases, duties predicted in the bench and compared in order.
// Depends on cct_mix_pkg and the cct_led_channel_mixer RTL.
module cct_led_channel_mixer_tb;
   import cct_mix_pkg::*;

   localparam int PIPE_DEPTH    = 7;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASE_ITEMS   = 300;
   localparam int NUM_PHASES    = 6;
   localparam int LONG_HOLD     = 80;
   localparam int MAX_REPORTS   = 10;
   localparam int WIDE_W        = 208;
   localparam int LUT_LAST      = 1 << GAMMA_INDEX_BITS;
   localparam logic [MODE_W-1:0] LIGHT_RELAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // Directed corner items: temperature and brightness pairs
   localparam int DAY_TEMPS [16] = '{0, 2699, 2700, 2701, 2999, 3000, 3500, 4000,
                                     4001, 4500, 5000, 5750, 6499, 6500, 6501, 65535};
   localparam int DAY_LEVELS [16] = '{4096, 8191, 4096, 1, 4096, 2048, 4096, 0,
                                      4097, 3000, 4096, 1234, 4096, 4096, 8191, 4096};
   localparam int NIGHT_TEMPS [5] = '{2700, 3000, 4500, 6500, 65535};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [MODE_W-1:0] csr_light_mode = LIGHT_DAY;

   // Handshake flags as seen at the last rising edge
   logic              req_fire = 1'b0;
   logic              csr_fire = 1'b0;

   // Bench copy of the mode register and the gamma curve
   logic [MODE_W-1:0] mode_now = LIGHT_DAY;
   logic [DUTY_W-1:0] gamma_lut [0:LUT_LAST];

   req_type           mix_req_q [$];
   bit                pause_before_q [$];
   rsp_type           duty_expect_q [$];

   int                fail_count = 0;
   int                cycle_count = 0;
   int                send_gap = 0;
   int                stall_left = 0;
   bit                send_idle_en = 1'b1;
   bit                recv_idle_en = 1'b1;
   bit                long_hold_go = 1'b0;
   bit                long_hold_done = 1'b0;

   cct_led_channel_mixer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_light_mode (csr_light_mode)
   );

   always #2 clock = ~clock;

   // Expected duties for one item under the given light mode
   function automatic rsp_type predict_duties(input req_type item, input logic [MODE_W-1:0] mode);
      rsp_type    r;
      longint     temp;
      longint     lvl;
      longint     span;
      longint     dt;
      longint     lo_duty;
      longint     hi_duty;
      longint     v;
      longint     prod;
      longint     idx;
      longint     duty [NUM_CH];
      logic [DUTY_W-1:0] g [NUM_CH];
      int         seg;
      int         ch;
      temp = item.color_temp;
      if (temp < KNOT_T[0]) begin
         temp = KNOT_T[0];
      end
      if (temp > KNOT_T[NUM_KNOTS-1]) begin
         temp = KNOT_T[NUM_KNOTS-1];
      end
      // pick the first segment whose upper knot is not below the temperature
      seg = 0;
      while (seg < NUM_KNOTS - 2 && temp > KNOT_T[seg+1]) begin
         seg++;
      end
      span = KNOT_T[seg+1] - KNOT_T[seg];
      dt   = temp - KNOT_T[seg];
      for (ch = 0; ch < NUM_CH; ch++) begin
         lo_duty  = (KNOT_HUND[seg][ch] * ONE + 50) / 100;
         hi_duty  = (KNOT_HUND[seg+1][ch] * ONE + 50) / 100;
         duty[ch] = (lo_duty * (span - dt) + hi_duty * dt + span / 2) / span;
      end
      // night: suppress blue, boost red
      if (mode == LIGHT_NIGHT) begin
         duty[3] = (duty[3] * NIGHT_BLUE_GAIN + NIGHT_ROUND) / 10;
         duty[2] = (duty[2] * NIGHT_RED_GAIN + NIGHT_ROUND) / 10;
      end
      lvl = item.brightness_level;
      if (lvl > ONE) begin
         lvl = ONE;
      end
      for (ch = 0; ch < NUM_CH; ch++) begin
         v     = (duty[ch] > ONE) ? ONE : duty[ch];
         prod  = (v * lvl + HALF) >> FRACTION_BITS;
         idx   = ((prod << GAMMA_INDEX_BITS) + HALF) >> FRACTION_BITS;
         g[ch] = gamma_lut[idx];
      end
      r.duty_ch1 = g[0];
      r.duty_ch2 = g[1];
      r.duty_ch3 = g[2];
      r.duty_ch4 = g[3];
      return r;
   endfunction

   // Random item, weighted toward the table span and in-range brightness
   function automatic req_type random_item();
      req_type it;
      int      t;
      int      b;
      case ($urandom_range(0, 9))
         0: t = $urandom_range(0, 65535);
         1: t = KNOT_T[$urandom_range(0, NUM_KNOTS - 1)] + $urandom_range(0, 4) - 2;
         default: t = $urandom_range(2600, 6600);
      endcase
      case ($urandom_range(0, 9))
         0, 1: b = $urandom_range(ONE + 1, 8191);
         2: b = $urandom_range(0, 15);
         3: b = ONE;
         default: b = $urandom_range(0, ONE);
      endcase
      it.color_temp       = TEMP_W'(t);
      it.brightness_level = LEVEL_W'(b);
      return it;
   endfunction

   task automatic add_item(input int t, input int b, input bit pause);
      req_type it;
      it.color_temp       = TEMP_W'(t);
      it.brightness_level = LEVEL_W'(b);
      mix_req_q.push_back(it);
      pause_before_q.push_back(pause);
   endtask

   // Hold until every item is sent and every result is back, then let the pipe settle
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (mix_req_q.size() != 0 || (req_valid && !req_fire) ||
                 duty_expect_q.size() != 0);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      csr_light_mode <= m;
      csr_valid      <= 1'b1;
      do begin
         @(negedge clock);
      end while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   // Request driver: hold until accepted, then idle or present the next item
   always @(negedge clock) begin
      if (req_valid && !req_fire) begin
         // keep offering the same item
      end else if (send_gap != 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (mix_req_q.size() == 0 ||
                   (pause_before_q[0] && duty_expect_q.size() != 0)) begin
         req_valid <= 1'b0;
      end else if (send_idle_en && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         send_gap  <= $urandom_range(0, 15);
      end else begin
         req_data  <= mix_req_q.pop_front();
         void'(pause_before_q.pop_front());
         req_valid <= 1'b1;
      end
   end

   // Result receiver: random stall bursts plus one long hold-off
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (long_hold_go && !long_hold_done) begin
         rsp_ready      <= 1'b0;
         stall_left     <= LONG_HOLD - 1;
         long_hold_done <= 1'b1;
      end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: record handshakes, predict on accept, check results in order
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      req_fire    <= req_valid && req_ready && !reset;
      csr_fire    <= csr_valid && csr_ready && !reset;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            mode_now <= csr_light_mode;
         end
         if (req_valid && req_ready) begin
            duty_expect_q.push_back(predict_duties(req_data, mode_now));
         end
         if (rsp_valid && rsp_ready) begin
            if (duty_expect_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < MAX_REPORTS) begin
                  $display("unexpected result: %0d %0d %0d %0d", rsp_data.duty_ch1,
                           rsp_data.duty_ch2, rsp_data.duty_ch3, rsp_data.duty_ch4);
               end
            end else begin
               want = duty_expect_q.pop_front();
               if (rsp_data.duty_ch1 !== want.duty_ch1 || rsp_data.duty_ch2 !== want.duty_ch2 ||
                   rsp_data.duty_ch3 !== want.duty_ch3 || rsp_data.duty_ch4 !== want.duty_ch4)
               begin
                  fail_count <= fail_count + 1;
                  if (fail_count < MAX_REPORTS) begin
                     $display("duty mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              want.duty_ch1, want.duty_ch2, want.duty_ch3, want.duty_ch4,
                              rsp_data.duty_ch1, rsp_data.duty_ch2, rsp_data.duty_ch3,
                              rsp_data.duty_ch4);
                  end
               end
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      logic [WIDE_W-1:0] k_pow;
      logic [WIDE_W-1:0] y_pow;
      int                k;
      int                y;
      int                j;
      int                p;
      int                n;
      bit                grow;
      logic [MODE_W-1:0] phase_mode [NUM_PHASES];

      // gamma curve: walk y upward, since the largest y with
      // y^11 * 2^(5G) <= k^5 * 2^(11(F+1)) never decreases with k
      y = 0;
      for (k = 0; k <= LUT_LAST; k++) begin
         k_pow = WIDE_W'(1);
         for (j = 0; j < 5; j++) begin
            k_pow = k_pow * WIDE_W'(k);
         end
         k_pow = k_pow << (11 * (FRACTION_BITS + 1));
         grow = 1'b1;
         while (grow && y < 2 * ONE) begin
            y_pow = WIDE_W'(1);
            for (j = 0; j < 11; j++) begin
               y_pow = y_pow * WIDE_W'(y + 1);
            end
            y_pow = y_pow << (5 * GAMMA_INDEX_BITS);
            if (y_pow <= k_pow) begin
               y++;
            end else begin
               grow = 1'b0;
            end
         end
         gamma_lut[k] = (((y + 1) >> 1) > ONE) ? DUTY_W'(ONE) : DUTY_W'((y + 1) >> 1);
      end

      phase_mode = '{LIGHT_NIGHT, LIGHT_RELAX, MODE_SPARE, LIGHT_DAY, LIGHT_NIGHT, LIGHT_DAY};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners in day mode, then a few in night mode
      write_mode(LIGHT_DAY);
      for (j = 0; j < 16; j++) begin
         add_item(DAY_TEMPS[j], DAY_LEVELS[j], 1'b0);
      end
      wait_idle();
      write_mode(LIGHT_NIGHT);
      for (j = 0; j < 5; j++) begin
         add_item(NIGHT_TEMPS[j], ONE, 1'b0);
      end
      wait_idle();

      // random phases, one light mode each
      for (p = 0; p < NUM_PHASES; p++) begin
         write_mode(phase_mode[p]);
         send_idle_en = (p == 0 || p == 2 || p == 3);
         recv_idle_en = (p == 0 || p == 2 || p == 4);
         // second phase: sender streams while the receiver holds off
         if (p == 1) begin
            long_hold_go = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            mix_req_q.push_back(random_item());
            pause_before_q.push_back(p == 2 && n == PHASE_ITEMS / 2);
         end
         wait_idle();
      end

      repeat (PIPE_DEPTH + 8) @(negedge clock);
      if (fail_count == 0 && duty_expect_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### cct_led_channel_mixer.f
design/cct_mix_pkg.sv
design/cct_mix_interp.sv
design/cct_mix_gamma_rom.sv
design/cct_mix_scale.sv
design/cct_led_channel_mixer.sv
design/cct_mix_checker.sv
sim/cct_led_channel_mixer_tb.sv
